// ----- rtl/register_machine_execute_top_assert.svh -----
// ----------------------------------------------------------------------------
// Register machine execute: assertion macros
// Immediate and next-cycle property checks, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef REGISTER_MACHINE_EXECUTE_TOP_ASSERT_SVH
`define REGISTER_MACHINE_EXECUTE_TOP_ASSERT_SVH

`ifndef SYNTH
`define REME_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("register machine check failed");
`define REME_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("register machine check failed");
`else
`define REME_ASSERT_NOW(label, ante, cons)
`define REME_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/reme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register machine execute package
// Sizes, opcode and status codes, operand use table and divider links.
// ----------------------------------------------------------------------------
package reme_pkg;

    localparam int NUM_REGS  = 16;
    localparam int MEM_WORDS = 32;
    localparam int DATA_W    = 32;
    localparam int PC_W      = 16;
    localparam int IDX_W     = 4;
    localparam int OP_W      = 4;
    localparam int IMM_W     = 15;
    localparam int ST_W      = 3;
    localparam int REG_AW    = $clog2(NUM_REGS);
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int DIV_CW    = $clog2(DATA_W);

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 4'd0,
        OP_MUL     = 4'd1,
        OP_SUB     = 4'd2,
        OP_DIV     = 4'd3,
        OP_COPY    = 4'd4,
        OP_IMM     = 4'd5,
        OP_LOAD    = 4'd6,
        OP_STORE   = 4'd7,
        OP_EQ      = 4'd8,
        OP_LT      = 4'd9,
        OP_LE      = 4'd10,
        OP_GT      = 4'd11,
        OP_GE      = 4'd12,
        OP_JMP     = 4'd13,
        OP_JMPZ    = 4'd14,
        OP_UNKNOWN = 4'd15
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_DIVZERO = 3'd1,
        ST_RANGE   = 3'd2,
        ST_BADIMM  = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    typedef struct packed {
        logic use_b;
        logic use_a;
        logic use_d;
    } t_use;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

    function automatic t_use op_use(input t_op op);
        t_use u;
        u = '0;
        case (op)
            OP_ADD, OP_MUL, OP_SUB, OP_DIV,
            OP_EQ, OP_LT, OP_LE, OP_GT, OP_GE: u = '{use_b: 1'b1, use_a: 1'b1, use_d: 1'b1};
            OP_COPY, OP_LOAD, OP_STORE, OP_JMPZ: u = '{use_b: 1'b0, use_a: 1'b1, use_d: 1'b1};
            OP_IMM, OP_JMP:                      u = '{use_b: 1'b0, use_a: 1'b0, use_d: 1'b1};
            default:                             u = '0;
        endcase
        return u;
    endfunction

    function automatic logic idx_bad(input logic [IDX_W-1:0] idx);
        return 32'(idx) >= NUM_REGS;
    endfunction

endpackage

// ----- rtl/reme_intf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register machine execute channels
// Instruction and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface reme_in_if;
    logic                             valid;
    logic                             ready;
    logic [reme_pkg::OP_W-1:0]        action;
    logic [reme_pkg::IDX_W-1:0]       dest_index;
    logic [reme_pkg::IDX_W-1:0]       src_a_index;
    logic [reme_pkg::IDX_W-1:0]       src_b_index;
    logic signed [reme_pkg::IMM_W-1:0] immediate;
    logic                             imm_is_register;

    modport source (
        output valid, action, dest_index, src_a_index, src_b_index, immediate,
               imm_is_register,
        input  ready
    );
    modport sink (
        input  valid, action, dest_index, src_a_index, src_b_index, immediate,
               imm_is_register,
        output ready
    );
endinterface

interface reme_out_if;
    logic                               valid;
    logic                               ready;
    logic [reme_pkg::ST_W-1:0]          status;
    logic [reme_pkg::PC_W-1:0]          next_pc;
    logic signed [reme_pkg::DATA_W-1:0] written_value;
    logic                               wrote;

    modport source (
        output valid, status, next_pc, written_value, wrote,
        input  ready
    );
    modport sink (
        input  valid, status, next_pc, written_value, wrote,
        output ready
    );
endinterface

// ----- rtl/register_machine_execute_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register machine execute top
// Executes one decoded three-address instruction per input transaction.
//
// i_in carries one decoded instruction per transaction; o_out returns one
// result transaction (status, next program counter, written value, write
// flag) for each instruction. Registers and data memory live in two
// synchronous RAMs; a valid bit per entry makes unwritten entries read zero.
// Register operands are read one per cycle through the single read port.
// An instruction passes through S_RD_A, S_RD_B, S_EXEC and S_WB before the
// next acceptance; a load adds S_LOAD (one extra data memory read) and a
// divide adds S_DIV, whose length the 32-step divider sets. Instructions
// flagged at decode (unknown opcode, register index out of range) go from
// acceptance straight to S_WB; every result is registered out from S_WB.
// Reset clears the program counter, all valid bits and the output valid flag.
// A result waits in the output register while the receiver stalls; the next
// instruction is accepted and runs until its own result is ready, then holds.
// ----------------------------------------------------------------------------
module register_machine_execute_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    reme_in_if.sink    i_in,
    reme_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_EXEC,
        S_DIV,
        S_LOAD,
        S_WB
    } t_state;

    t_state                           r_state;
    t_state                           n_exec_state;
    logic [reme_pkg::PC_W-1:0]        r_pc;
    logic [reme_pkg::NUM_REGS-1:0]    r_reg_vld;
    logic [reme_pkg::MEM_WORDS-1:0]   r_mem_vld;

    reme_pkg::t_op                    r_op;
    logic [reme_pkg::IDX_W-1:0]       r_di;
    logic [reme_pkg::IDX_W-1:0]       r_ai;
    logic [reme_pkg::IDX_W-1:0]       r_bi;
    logic [reme_pkg::IMM_W-1:0]       r_imm;
    logic                             r_immreg;
    logic [reme_pkg::DATA_W-1:0]      r_vd;
    logic [reme_pkg::DATA_W-1:0]      r_va;
    logic                             r_div_neg;

    reme_pkg::t_status                r_status;
    logic [reme_pkg::PC_W-1:0]        r_next;
    logic [reme_pkg::DATA_W-1:0]      r_val;
    logic                             r_wrote;

    logic                             r_out_valid;
    reme_pkg::t_status                r_out_status;
    logic [reme_pkg::PC_W-1:0]        r_out_next_pc;
    logic [reme_pkg::DATA_W-1:0]      r_out_value;
    logic                             r_out_wrote;

    reme_pkg::t_op                    n_in_op;
    reme_pkg::t_use                   n_in_use;
    logic                             n_in_bad;
    reme_pkg::t_status                n_status;
    logic [reme_pkg::PC_W-1:0]        n_next;
    logic [reme_pkg::DATA_W-1:0]      n_val;
    logic                             n_wrote;

    logic [reme_pkg::REG_AW-1:0]      reg_raddr;
    logic [reme_pkg::DATA_W-1:0]      reg_rd_raw;
    logic [reme_pkg::DATA_W-1:0]      reg_rd_data;
    logic                             reg_rd_vld;
    logic                             reg_we;
    logic [reme_pkg::DATA_W-1:0]      mem_rd_raw;
    logic [reme_pkg::DATA_W-1:0]      mem_rd_data;
    logic                             mem_we;
    logic                             wb_fire;
    logic                             is_store;
    logic                             addr_ok;
    logic                             jump_ok;
    logic [reme_pkg::DATA_W-1:0]      mag_a;
    logic [reme_pkg::DATA_W-1:0]      mag_b;

    reme_pkg::t_div_req               div_req;
    reme_pkg::t_div_rsp               div_rsp;

    // decode-time checks
    always_comb begin
        n_in_op  = reme_pkg::t_op'(i_in.action);
        n_in_use = reme_pkg::op_use(n_in_op);
        n_in_bad = (n_in_use.use_d && reme_pkg::idx_bad(i_in.dest_index)) ||
                   (n_in_use.use_a && reme_pkg::idx_bad(i_in.src_a_index)) ||
                   (n_in_use.use_b && reme_pkg::idx_bad(i_in.src_b_index));
    end

    // register file read port
    always_comb begin
        case (r_state)
            S_RD_A:  reg_raddr = r_ai[reme_pkg::REG_AW-1:0];
            S_RD_B:  reg_raddr = r_bi[reme_pkg::REG_AW-1:0];
            default: reg_raddr = i_in.dest_index[reme_pkg::REG_AW-1:0];
        endcase
        case (r_state)
            S_RD_A:  reg_rd_vld = r_reg_vld[r_di[reme_pkg::REG_AW-1:0]];
            S_RD_B:  reg_rd_vld = r_reg_vld[r_ai[reme_pkg::REG_AW-1:0]];
            S_EXEC:  reg_rd_vld = r_reg_vld[r_bi[reme_pkg::REG_AW-1:0]];
            default: reg_rd_vld = 1'b0;
        endcase
        reg_rd_data = reg_rd_raw & {reme_pkg::DATA_W{reg_rd_vld}};
        mem_rd_data = mem_rd_raw &
                      {reme_pkg::DATA_W{r_mem_vld[r_va[reme_pkg::MEM_AW-1:0]]}};
    end

    // execute: reg_rd_data holds the second source during S_EXEC
    always_comb begin
        addr_ok = 1'b0;
        jump_ok = (r_vd[reme_pkg::DATA_W-1:reme_pkg::PC_W] == '0);
        mag_a   = r_va[reme_pkg::DATA_W-1] ? (~r_va + 1'b1) : r_va;
        mag_b   = reg_rd_data[reme_pkg::DATA_W-1] ? (~reg_rd_data + 1'b1) : reg_rd_data;
        n_status     = reme_pkg::ST_OK;
        n_next       = r_next;
        n_val        = '0;
        n_wrote      = 1'b0;
        n_exec_state = S_WB;
        case (r_op)
            reme_pkg::OP_ADD: begin
                n_val = r_va + reg_rd_data; n_wrote = 1'b1;
            end
            reme_pkg::OP_MUL: begin
                n_val = r_va * reg_rd_data; n_wrote = 1'b1;
            end
            reme_pkg::OP_SUB: begin
                n_val = r_va - reg_rd_data; n_wrote = 1'b1;
            end
            reme_pkg::OP_DIV: begin
                if (reg_rd_data == '0) begin
                    n_status = reme_pkg::ST_DIVZERO;
                end else begin
                    n_exec_state = S_DIV;
                end
            end
            reme_pkg::OP_COPY: begin
                n_val = r_va; n_wrote = 1'b1;
            end
            reme_pkg::OP_IMM: begin
                if (r_immreg) begin
                    n_status = reme_pkg::ST_BADIMM;
                end else begin
                    n_val   = {{(reme_pkg::DATA_W - reme_pkg::IMM_W){r_imm[reme_pkg::IMM_W-1]}},
                               r_imm};
                    n_wrote = 1'b1;
                end
            end
            reme_pkg::OP_LOAD: begin
                addr_ok = !r_va[reme_pkg::DATA_W-1] && (r_va < 32'(reme_pkg::MEM_WORDS));
                if (!addr_ok) begin
                    n_status = reme_pkg::ST_RANGE;
                end else begin
                    n_exec_state = S_LOAD;
                end
            end
            reme_pkg::OP_STORE: begin
                addr_ok = !r_vd[reme_pkg::DATA_W-1] && (r_vd < 32'(reme_pkg::MEM_WORDS));
                if (!addr_ok) begin
                    n_status = reme_pkg::ST_RANGE;
                end else begin
                    n_val = r_va; n_wrote = 1'b1;
                end
            end
            reme_pkg::OP_EQ: begin
                n_val = {{(reme_pkg::DATA_W-1){1'b0}}, (r_va == reg_rd_data)}; n_wrote = 1'b1;
            end
            reme_pkg::OP_LT: begin
                n_val = {{(reme_pkg::DATA_W-1){1'b0}}, ($signed(r_va) < $signed(reg_rd_data))};
                n_wrote = 1'b1;
            end
            reme_pkg::OP_LE: begin
                n_val = {{(reme_pkg::DATA_W-1){1'b0}}, ($signed(r_va) <= $signed(reg_rd_data))};
                n_wrote = 1'b1;
            end
            reme_pkg::OP_GT: begin
                n_val = {{(reme_pkg::DATA_W-1){1'b0}}, ($signed(r_va) > $signed(reg_rd_data))};
                n_wrote = 1'b1;
            end
            reme_pkg::OP_GE: begin
                n_val = {{(reme_pkg::DATA_W-1){1'b0}}, ($signed(r_va) >= $signed(reg_rd_data))};
                n_wrote = 1'b1;
            end
            reme_pkg::OP_JMP: begin
                if (!jump_ok) begin
                    n_status = reme_pkg::ST_RANGE;
                end else begin
                    n_next = r_vd[reme_pkg::PC_W-1:0];
                end
            end
            reme_pkg::OP_JMPZ: begin
                if (r_va == '0) begin
                    if (!jump_ok) begin
                        n_status = reme_pkg::ST_RANGE;
                    end else begin
                        n_next = r_vd[reme_pkg::PC_W-1:0];
                    end
                end
            end
            default: begin
                n_status = reme_pkg::ST_UNKNOWN;
            end
        endcase
    end

    assign div_req.start    = (r_state == S_EXEC) && (n_exec_state == S_DIV);
    assign div_req.dividend = mag_a;
    assign div_req.divisor  = mag_b;

    assign is_store = (r_op == reme_pkg::OP_STORE);
    assign wb_fire  = (r_state == S_WB) && (!r_out_valid || o_out.ready);
    assign reg_we   = wb_fire && r_wrote && !is_store;
    assign mem_we   = wb_fire && r_wrote && is_store;

    reme_ram #(
        .WIDTH (reme_pkg::DATA_W),
        .DEPTH (reme_pkg::NUM_REGS)
    ) u_reg_ram (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_waddr (r_di[reme_pkg::REG_AW-1:0]),
        .i_wdata (r_val),
        .i_raddr (reg_raddr),
        .o_rdata (reg_rd_raw)
    );

    reme_ram #(
        .WIDTH (reme_pkg::DATA_W),
        .DEPTH (reme_pkg::MEM_WORDS)
    ) u_mem_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_vd[reme_pkg::MEM_AW-1:0]),
        .i_wdata (r_val),
        .i_raddr (r_va[reme_pkg::MEM_AW-1:0]),
        .o_rdata (mem_rd_raw)
    );

    reme_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_reg_vld   <= '0;
            r_mem_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op     <= n_in_op;
                        r_di     <= i_in.dest_index;
                        r_ai     <= i_in.src_a_index;
                        r_bi     <= i_in.src_b_index;
                        r_imm    <= i_in.immediate;
                        r_immreg <= i_in.imm_is_register;
                        r_status <= reme_pkg::ST_OK;
                        r_val    <= '0;
                        r_wrote  <= 1'b0;
                        r_next   <= r_pc + 1'b1;
                        if (n_in_op == reme_pkg::OP_UNKNOWN) begin
                            r_status <= reme_pkg::ST_UNKNOWN;
                            r_next   <= r_pc;
                            r_state  <= S_WB;
                        end else if (n_in_bad) begin
                            r_status <= reme_pkg::ST_RANGE;
                            r_state  <= S_WB;
                        end else begin
                            r_state <= S_RD_A;
                        end
                    end
                end
                S_RD_A: begin
                    r_vd    <= reg_rd_data;
                    r_state <= S_RD_B;
                end
                S_RD_B: begin
                    r_va    <= reg_rd_data;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_status  <= n_status;
                    r_next    <= n_next;
                    r_val     <= n_val;
                    r_wrote   <= n_wrote;
                    r_div_neg <= r_va[reme_pkg::DATA_W-1] ^ reg_rd_data[reme_pkg::DATA_W-1];
                    r_state   <= n_exec_state;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_val   <= r_div_neg ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
                        r_wrote <= 1'b1;
                        r_state <= S_WB;
                    end
                end
                S_LOAD: begin
                    r_val   <= mem_rd_data;
                    r_wrote <= 1'b1;
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (wb_fire) begin
                        r_out_valid   <= 1'b1;
                        r_out_status  <= r_status;
                        r_out_next_pc <= r_next;
                        r_out_value   <= r_val;
                        r_out_wrote   <= r_wrote;
                        r_pc          <= r_next;
                        if (reg_we) begin
                            r_reg_vld[r_di[reme_pkg::REG_AW-1:0]] <= 1'b1;
                        end
                        if (mem_we) begin
                            r_mem_vld[r_vd[reme_pkg::MEM_AW-1:0]] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready          = i_rst_n && (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.next_pc       = r_out_next_pc;
    assign o_out.written_value = r_out_value;
    assign o_out.wrote         = r_out_wrote;

`include "register_machine_execute_top_assert.svh"

    `REME_ASSERT_NOW(a_div_done_in_div, div_rsp.done, r_state == S_DIV)
    `REME_ASSERT_NEXT(a_pc_hold, !wb_fire, $stable(r_pc))
    `REME_ASSERT_NOW(a_err_no_write, r_out_valid && (r_out_status != reme_pkg::ST_OK), !r_out_wrote)
    `REME_ASSERT_NOW(a_unknown_pc, r_state == S_WB && r_status == reme_pkg::ST_UNKNOWN, r_next == r_pc)

endmodule

// ----- rtl/reme_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module reme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/reme_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register machine divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module reme_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  reme_pkg::t_div_req  i_req,
    output reme_pkg::t_div_rsp  o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [reme_pkg::DIV_CW-1:0]     r_cnt;
    logic [reme_pkg::DATA_W-1:0]     r_quo;
    logic [reme_pkg::DATA_W-1:0]     r_rem;
    logic [reme_pkg::DATA_W-1:0]     r_dvs;
    logic [reme_pkg::DATA_W:0]       n_shift;
    logic [reme_pkg::DATA_W:0]       n_diff;
    logic                            n_ge;

    always_comb begin
        n_shift = {r_rem, r_quo[reme_pkg::DATA_W-1]};
        n_diff  = n_shift - {1'b0, r_dvs};
        n_ge    = !n_diff[reme_pkg::DATA_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[reme_pkg::DATA_W-1:0] : n_shift[reme_pkg::DATA_W-1:0];
                r_quo <= {r_quo[reme_pkg::DATA_W-2:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == reme_pkg::DIV_CW'(reme_pkg::DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
